// File: rtl/rer_pkg.sv
// shared constants, command and mode codes, and the clip register struct
// for the rectangle and ellipse rasteriser; no dependencies
`default_nettype none

package rer_pkg;

  localparam int COORD_BITS = 13;
  localparam int SPAN_BITS  = COORD_BITS - 1;
  localparam int PIX_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * SPAN_BITS;
  localparam int PROD_BITS  = 2 * SQ_BITS;
  localparam int COLOR_BITS = 24;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [1:0] CMD_RECT    = 2'd0;
  localparam logic [1:0] CMD_ELLIPSE = 2'd1;
  localparam logic [1:0] CMD_NEXT    = 2'd2;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RECT    = 2'd1;
  localparam logic [1:0] MODE_ELLIPSE = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(480);

  typedef struct packed {
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
  } clip_cfg_t;

endpackage

`default_nettype wire

// File: rtl/rer_mul.sv
// shared square and product unit with a registered result
// depends on rer_pkg
`default_nettype none

module rer_mul (
  input  wire logic                          clk,
  input  wire logic [rer_pkg::SQ_BITS-1:0]   a,
  input  wire logic [rer_pkg::SQ_BITS-1:0]   b,
  output logic      [rer_pkg::PROD_BITS-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{rer_pkg::SQ_BITS{1'b0}}, a} * {{rer_pkg::SQ_BITS{1'b0}}, b};
  end

endmodule

`default_nettype wire

// File: rtl/rer_cfg.sv
// apb register file holding the clip screen size
// depends on rer_pkg
`default_nettype none

module rer_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rer_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [rer_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [rer_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  output rer_pkg::clip_cfg_t                     clip
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.width  <= rer_pkg::WIDTH_RESET;
      clip.height <= rer_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        rer_pkg::REG_WIDTH:  clip.width  <= pwdata[rer_pkg::COORD_BITS-1:0];
        rer_pkg::REG_HEIGHT: clip.height <= pwdata[rer_pkg::COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rer_pkg::REG_WIDTH:
        prdata = rer_pkg::APB_DATA_BITS'(clip.width);
      rer_pkg::REG_HEIGHT:
        prdata = rer_pkg::APB_DATA_BITS'(clip.height);
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rect_ellipse_fill_rasterizer_top.sv
// top level: command sequencer, scan counters, ellipse test on the shared
// multiplier and output register; depends on rer_pkg, rer_mul, rer_cfg
//
//   channel  | handshake                  | payload
//   input    | in_valid / in_ready        | cmd origin_x origin_y extent_x extent_y color
//   output   | out_valid / out_ready      | pixel_x pixel_y pixel_color draw last
//   config   | psel penable pwrite pready | paddr pwdata prdata
//
// begin rectangle registers the shape and stays idle; begin ellipse runs rx^2, ry^2, rx^2*ry^2 on the multiplier
// next on a rectangle or zero-radius ellipse goes straight to the output state; next on an ellipse
// first makes four passes through the one registered 24x24 multiplier
// in_ready is high only while the sequencer is idle
// a finished position waits in its state until the output register is free
// synchronous reset: idle, no shape, output empty, screen 640 x 480
`default_nettype none

module rect_ellipse_fill_rasterizer_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            cmd,
  input  wire logic signed [rer_pkg::COORD_BITS-1:0] origin_x,
  input  wire logic signed [rer_pkg::COORD_BITS-1:0] origin_y,
  input  wire logic [rer_pkg::SPAN_BITS-1:0]         extent_x,
  input  wire logic [rer_pkg::SPAN_BITS-1:0]         extent_y,
  input  wire logic [rer_pkg::COLOR_BITS-1:0]        color,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [rer_pkg::PIX_BITS-1:0]        pixel_x,
  output logic signed [rer_pkg::PIX_BITS-1:0]        pixel_y,
  output logic [rer_pkg::COLOR_BITS-1:0]             pixel_color,
  output logic                                       draw,
  output logic                                       last,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [rer_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  wire logic [rer_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [rer_pkg::APB_DATA_BITS-1:0]          prdata,
  output logic                                       pready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BRX  = 4'd1;
  localparam logic [3:0] ST_BRY  = 4'd2;
  localparam logic [3:0] ST_BRP  = 4'd3;
  localparam logic [3:0] ST_BEND = 4'd4;
  localparam logic [3:0] ST_P0   = 4'd5;
  localparam logic [3:0] ST_P1   = 4'd6;
  localparam logic [3:0] ST_P2   = 4'd7;
  localparam logic [3:0] ST_P3   = 4'd8;
  localparam logic [3:0] ST_P4   = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  localparam int CB = rer_pkg::COORD_BITS;
  localparam int SB = rer_pkg::SPAN_BITS;
  localparam int PB = rer_pkg::PIX_BITS;
  localparam int QB = rer_pkg::SQ_BITS;
  localparam int RB = rer_pkg::PROD_BITS;

  rer_pkg::clip_cfg_t clip;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] mode;

  logic signed [CB-1:0] base_x;
  logic signed [CB-1:0] base_y;
  logic [SB-1:0]        span_x;
  logic [SB-1:0]        span_y;
  logic signed [CB-1:0] offset_x;
  logic signed [CB-1:0] offset_y;
  logic [rer_pkg::COLOR_BITS-1:0] pen_color;
  logic [QB-1:0]        rx2;
  logic [QB-1:0]        ry2;
  logic [RB-1:0]        radius_product;
  logic [RB-1:0]        acc;
  logic                 in_shape;

  logic [QB-1:0] mul_a;
  logic [QB-1:0] mul_b;
  logic [RB-1:0] mul_q;

  logic acc_in;
  logic begin_rect;
  logic begin_ell;
  logic next_go;
  logic span_zero;
  logic out_load;

  logic [SB-1:0]        abs_x;
  logic [SB-1:0]        abs_y;
  logic [RB:0]          sum;
  logic signed [PB-1:0] px;
  logic signed [PB-1:0] py;
  logic signed [PB-1:0] off_x_e;
  logic signed [PB-1:0] off_y_e;
  logic signed [PB-1:0] end_x;
  logic signed [PB-1:0] end_y;
  logic signed [CB-1:0] start_x;
  logic                 onscreen;
  logic                 last_c;

  rer_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clip    (clip)
  );

  rer_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_q)
  );

  assign in_ready   = (state == ST_IDLE);
  assign acc_in     = in_valid && in_ready;
  assign begin_rect = acc_in && (cmd == rer_pkg::CMD_RECT);
  assign begin_ell  = acc_in && (cmd == rer_pkg::CMD_ELLIPSE);
  assign next_go    = acc_in && (cmd == rer_pkg::CMD_NEXT) && (mode != rer_pkg::MODE_IDLE);
  assign span_zero  = (span_x == '0) || (span_y == '0);
  assign out_load   = (state == ST_OUT) && (!out_valid || out_ready);

  assign abs_x = offset_x[CB-1] ? SB'(-offset_x) : SB'(offset_x);
  assign abs_y = offset_y[CB-1] ? SB'(-offset_y) : SB'(offset_y);
  assign sum   = {1'b0, acc} + {1'b0, mul_q};

  assign off_x_e = {offset_x[CB-1], offset_x};
  assign off_y_e = {offset_y[CB-1], offset_y};
  assign px      = {base_x[CB-1], base_x} + off_x_e;
  assign py      = {base_y[CB-1], base_y} + off_y_e;

  always_comb begin
    if (mode == rer_pkg::MODE_ELLIPSE) begin
      end_x   = $signed({2'b00, span_x});
      end_y   = $signed({2'b00, span_y});
      start_x = -$signed({1'b0, span_x});
    end else begin
      end_x   = $signed({2'b00, span_x}) - PB'(1);
      end_y   = $signed({2'b00, span_y}) - PB'(1);
      start_x = '0;
    end
  end

  assign onscreen = !px[PB-1] && !py[PB-1] &&
                    (PB'(px) < {1'b0, clip.width}) && (PB'(py) < {1'b0, clip.height});
  assign last_c   = (off_x_e >= end_x) && (off_y_e >= end_y);

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state)
      ST_BRX: begin
        mul_a = QB'(span_x);
        mul_b = QB'(span_x);
      end
      ST_BRY: begin
        mul_a = QB'(span_y);
        mul_b = QB'(span_y);
      end
      ST_BRP: begin
        mul_a = rx2;
        mul_b = mul_q[QB-1:0];
      end
      ST_P0: begin
        mul_a = QB'(abs_x);
        mul_b = QB'(abs_x);
      end
      ST_P1: begin
        mul_a = mul_q[QB-1:0];
        mul_b = ry2;
      end
      ST_P2: begin
        mul_a = QB'(abs_y);
        mul_b = QB'(abs_y);
      end
      ST_P3: begin
        mul_a = mul_q[QB-1:0];
        mul_b = rx2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        if (begin_ell) begin
          state_next = ST_BRX;
        end else if (next_go) begin
          state_next = (mode == rer_pkg::MODE_ELLIPSE && !span_zero) ? ST_P0 : ST_OUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BRX:  state_next = ST_BRY;
      ST_BRY:  state_next = ST_BRP;
      ST_BRP:  state_next = ST_BEND;
      ST_BEND: state_next = ST_IDLE;
      ST_P0:   state_next = ST_P1;
      ST_P1:   state_next = ST_P2;
      ST_P2:   state_next = ST_P3;
      ST_P3:   state_next = ST_P4;
      ST_P4:   state_next = ST_OUT;
      ST_OUT:  state_next = out_load ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= rer_pkg::MODE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (begin_rect) begin
        mode <= (extent_x == '0 || extent_y == '0) ? rer_pkg::MODE_IDLE : rer_pkg::MODE_RECT;
      end else if (begin_ell) begin
        mode <= rer_pkg::MODE_ELLIPSE;
      end else if (out_load && last_c) begin
        mode <= rer_pkg::MODE_IDLE;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (begin_rect || begin_ell) begin
      base_x    <= origin_x;
      base_y    <= origin_y;
      span_x    <= extent_x;
      span_y    <= extent_y;
      pen_color <= color;
    end
    if (begin_rect) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (begin_ell) begin
      offset_x <= -$signed({1'b0, extent_x});
      offset_y <= -$signed({1'b0, extent_y});
    end else if (out_load && !last_c) begin
      if (off_x_e < end_x) begin
        offset_x <= offset_x + CB'(1);
      end else begin
        offset_x <= start_x;
        offset_y <= offset_y + CB'(1);
      end
    end
    if (state == ST_BRY) begin
      rx2 <= mul_q[QB-1:0];
    end
    if (state == ST_BRP) begin
      ry2 <= mul_q[QB-1:0];
    end
    if (state == ST_BEND) begin
      radius_product <= mul_q;
    end
    if (state == ST_P2) begin
      acc <= mul_q;
    end
    if (next_go) begin
      in_shape <= (mode == rer_pkg::MODE_RECT);
    end else if (state == ST_P4) begin
      in_shape <= (sum <= {1'b0, radius_product});
    end
    if (out_load) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= pen_color;
      draw        <= in_shape && onscreen;
      last        <= last_c;
    end
  end

`ifndef SYNTHESIS
  a_ellipse_path_needs_ellipse: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P0) |-> (mode == rer_pkg::MODE_ELLIPSE && !span_zero))
    else $error("ellipse test started without an ellipse");

  a_last_ends_shape: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_c) |=> (mode == rer_pkg::MODE_IDLE))
    else $error("shape still active after its last transfer");

  a_radius_product: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && mode == rer_pkg::MODE_ELLIPSE) |->
    (radius_product == {{QB{1'b0}}, rx2} * {{QB{1'b0}}, ry2}))
    else $error("radius product out of step with radii");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (mode == rer_pkg::MODE_ELLIPSE && state == ST_IDLE) |->
    ((off_y_e <= $signed({2'b00, span_y})) && (off_y_e >= -$signed({2'b00, span_y}))))
    else $error("ellipse row offset outside radius");
`endif

endmodule

`default_nettype wire

// File: tb/tb_rect_ellipse_fill_rasterizer_top.sv
// self-checking bench for rect_ellipse_fill_rasterizer_top: table-driven and random shape scans
// scored against an in-bench scan predictor, clip sizes changed over the APB port
// depends on rer_pkg and the rasteriser top level
`default_nettype none

module tb_rect_ellipse_fill_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = rer_pkg::COORD_BITS;
  localparam int SB = rer_pkg::SPAN_BITS;
  localparam int PB = rer_pkg::PIX_BITS;
  localparam int KB = rer_pkg::COLOR_BITS;
  localparam int AB = rer_pkg::APB_ADDR_BITS;
  localparam int DB = rer_pkg::APB_DATA_BITS;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int WD_LIMIT     = 4000;
  localparam int PHASE_ITEMS  = 330;
  localparam int N_PHASES     = 6;
  localparam int PHASE_W [N_PHASES] = '{8, 1, 4096, 0, 8191, 13};
  localparam int PHASE_H [N_PHASES] = '{6, 1, 4096, 8191, 0, 3};

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [PB-1:0] x;
    logic signed [PB-1:0] y;
    logic [KB-1:0]        color;
    logic                 draw;
    logic                 last;
  } pixel_t;

  typedef enum {ITEM_IGNORED, ITEM_BEGIN, ITEM_PIXEL} item_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIXEL} row_chk_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [CB-1:0] ox;
    logic signed [CB-1:0] oy;
    logic [SB-1:0]        ex;
    logic [SB-1:0]        ey;
    logic [KB-1:0]        col;
    row_chk_t             chk;
    pixel_t               want;
  } dir_row_t;

  localparam pixel_t NO_PIX = '0;

  localparam logic [1:0] C_RECT = rer_pkg::CMD_RECT;
  localparam logic [1:0] C_ELL  = rer_pkg::CMD_ELLIPSE;
  localparam logic [1:0] C_NEXT = rer_pkg::CMD_NEXT;

  localparam dir_row_t DIR_ROWS [24] = '{
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_NONE, NO_PIX},
    '{CMD_UNUSED, 13'h1555, 13'h0AAA, 12'hFFF, 12'h555, 24'hA5A5A5, CHK_NONE, NO_PIX},
    '{C_RECT, 13'd0, 13'd0, 12'd1, 12'd1, 24'hFFFFFF, CHK_NONE, NO_PIX},
    '{C_NEXT, 13'h1FFF, 13'h1FFF, 12'hFFF, 12'hFFF, 24'h000000, CHK_PIXEL,
      '{14'sd0, 14'sd0, 24'hFFFFFF, 1'b1, 1'b1}},
    '{C_RECT, 13'h1000, 13'h1000, 12'd0, 12'd5, 24'h00AA55, CHK_NONE, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_NONE, NO_PIX},
    '{C_RECT, 13'h0FFF, 13'h0FFF, 12'hFFF, 12'hFFF, 24'h000000, CHK_NONE, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'hFFFFFF, CHK_PIXEL,
      '{14'sd4095, 14'sd4095, 24'h000000, 1'b0, 1'b0}},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_ELL, 13'h1000, 13'h1000, 12'hFFF, 12'hFFF, 24'h00FF00, CHK_NONE, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_PIXEL,
      '{-14'sd8191, -14'sd8191, 24'h00FF00, 1'b0, 1'b0}},
    '{C_ELL, 13'd10, 13'd10, 12'd0, 12'd0, 24'h123456, CHK_NONE, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_PIXEL,
      '{14'sd10, 14'sd10, 24'h123456, 1'b0, 1'b1}},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_NONE, NO_PIX},
    '{C_ELL, 13'd639, 13'd479, 12'd1, 12'd1, 24'hABCDEF, CHK_NONE, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX},
    '{C_NEXT, 13'd0, 13'd0, 12'd0, 12'd0, 24'h000000, CHK_MODEL, NO_PIX}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] cmd = '0;
  logic signed [CB-1:0] origin_x = '0;
  logic signed [CB-1:0] origin_y = '0;
  logic [SB-1:0] extent_x = '0;
  logic [SB-1:0] extent_y = '0;
  logic [KB-1:0] color = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AB-1:0] paddr = '0;
  logic [DB-1:0] pwdata = '0;

  logic in_ready;
  logic out_valid;
  logic signed [PB-1:0] pixel_x;
  logic signed [PB-1:0] pixel_y;
  logic [KB-1:0] pixel_color;
  logic draw;
  logic last;
  logic [DB-1:0] prdata;
  logic pready;

  rect_ellipse_fill_rasterizer_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .origin_x(origin_x), .origin_y(origin_y),
    .extent_x(extent_x), .extent_y(extent_y), .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
    .draw(draw), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scan predictor state
  logic [1:0]    scan_mode = rer_pkg::MODE_IDLE;
  int            org_x = 0;
  int            org_y = 0;
  int            span_w = 0;
  int            span_h = 0;
  int            step_x = 0;
  int            step_y = 0;
  logic [KB-1:0] ink = '0;
  u64_t          rr_prod = 0;
  int            clip_w = 640;
  int            clip_h = 480;

  pixel_t     pending_pixels [$];
  item_kind_t last_kind;
  int         errors = 0;
  int         eff_items = 0;
  int         shapes_begun = 0;
  int         pixels_seen = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stall_reqs = 0;
  int         stall_served = 0;
  int         stall_left = 0;

  function automatic item_kind_t raster_advance(input logic [1:0] c,
                                                input logic signed [CB-1:0] ox,
                                                input logic signed [CB-1:0] oy,
                                                input logic [SB-1:0] ex,
                                                input logic [SB-1:0] ey,
                                                input logic [KB-1:0] col,
                                                output pixel_t pix);
    u64_t ax, ay, rx2, ry2;
    int px, py, start_x, end_x, end_y;
    bit in_shape, onscreen, fin;
    pix = '0;
    if (c == rer_pkg::CMD_RECT || c == rer_pkg::CMD_ELLIPSE) begin
      org_x = int'(ox);
      org_y = int'(oy);
      span_w = int'(ex);
      span_h = int'(ey);
      ink = col;
      if (c == rer_pkg::CMD_RECT) begin
        scan_mode = (span_w == 0 || span_h == 0) ? rer_pkg::MODE_IDLE : rer_pkg::MODE_RECT;
        step_x = 0;
        step_y = 0;
        rr_prod = 0;
      end else begin
        rx2 = span_w * span_w;
        ry2 = span_h * span_h;
        scan_mode = rer_pkg::MODE_ELLIPSE;
        step_x = -span_w;
        step_y = -span_h;
        rr_prod = rx2 * ry2;
      end
      return ITEM_BEGIN;
    end
    if (c != rer_pkg::CMD_NEXT || scan_mode == rer_pkg::MODE_IDLE) return ITEM_IGNORED;
    px = org_x + step_x;
    py = org_y + step_y;
    in_shape = 1'b1;
    if (scan_mode == rer_pkg::MODE_ELLIPSE) begin
      if (span_w == 0 || span_h == 0) begin
        in_shape = 1'b0;
      end else begin
        ax = (step_x < 0) ? -step_x : step_x;
        ay = (step_y < 0) ? -step_y : step_y;
        rx2 = span_w * span_w;
        ry2 = span_h * span_h;
        in_shape = (ax * ax * ry2 + ay * ay * rx2) <= rr_prod;
      end
      start_x = -span_w;
      end_x = span_w;
      end_y = span_h;
    end else begin
      start_x = 0;
      end_x = span_w - 1;
      end_y = span_h - 1;
    end
    onscreen = px >= 0 && py >= 0 && px < clip_w && py < clip_h;
    fin = step_x >= end_x && step_y >= end_y;
    pix.x = PB'(px);
    pix.y = PB'(py);
    pix.color = ink;
    pix.draw = in_shape && onscreen;
    pix.last = fin;
    if (fin) begin
      scan_mode = rer_pkg::MODE_IDLE;
    end else if (step_x < end_x) begin
      step_x++;
    end else begin
      step_x = start_x;
      step_y++;
    end
    return ITEM_PIXEL;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("%s", msg);
  endtask

  // one input transfer, then the predictor sees the item
  task automatic send_item(input logic [1:0] c, input logic [CB-1:0] ox,
                           input logic [CB-1:0] oy, input logic [SB-1:0] ex,
                           input logic [SB-1:0] ey, input logic [KB-1:0] col);
    pixel_t pix;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    origin_x <= ox;
    origin_y <= oy;
    extent_x <= ex;
    extent_y <= ey;
    color <= col;
    do @(posedge clk); while (!in_ready);
    last_kind = raster_advance(c, ox, oy, ex, ey, col, pix);
    if (last_kind != ITEM_IGNORED) eff_items++;
    if (last_kind == ITEM_BEGIN) shapes_begun++;
    if (last_kind == ITEM_PIXEL) pending_pixels.push_back(pix);
  endtask

  task automatic apb_write(input logic idx, input logic [DB-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check(input logic idx, input int want);
    logic [DB-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== DB'(want))
      report($sformatf("register %0d read %0d, want %0d", idx, rd, want));
  endtask

  task automatic set_clip(input int w, input int h);
    logic [DB-1:0] junk;
    junk = $urandom & ~32'h1FFF;
    apb_write(rer_pkg::REG_WIDTH, junk | DB'(w));
    clip_w = w & 32'h1FFF;
    junk = $urandom & ~32'h1FFF;
    apb_write(rer_pkg::REG_HEIGHT, junk | DB'(h));
    clip_h = h & 32'h1FFF;
    apb_check(rer_pkg::REG_WIDTH, clip_w);
    apb_check(rer_pkg::REG_HEIGHT, clip_h);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 34;
        recv_idle_pct <= 60;
      end
      1: begin
        send_idle_pct = 60;
        recv_idle_pct <= 34;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  function automatic logic [CB-1:0] near_edge(input int lim);
    if ($urandom_range(0, 1)) return CB'(int'($urandom_range(0, 20)) - 8);
    return CB'(lim - int'($urandom_range(0, 10)));
  endfunction

  // a begin and its scan, sometimes cut short, huge or plain noise
  task automatic draw_shape();
    int n_pix;
    bit ell, big;
    logic [SB-1:0] ex, ey;
    logic [CB-1:0] ox, oy;
    if ($urandom_range(0, 99) < 15) begin
      send_item(2'($urandom_range(0, 3)), CB'($urandom), CB'($urandom), SB'($urandom),
                SB'($urandom), KB'($urandom));
      return;
    end
    ell = 1'($urandom_range(0, 1));
    big = ($urandom_range(0, 19) == 0);
    if (big) begin
      ex = SB'($urandom);
      ey = SB'($urandom);
      ox = CB'($urandom);
      oy = CB'($urandom);
      n_pix = $urandom_range(1, 12);
    end else begin
      ex = SB'($urandom_range(0, ell ? 4 : 9));
      ey = SB'($urandom_range(0, ell ? 4 : 9));
      ox = near_edge(clip_w);
      oy = near_edge(clip_h);
      n_pix = ell ? (2 * int'(ex) + 1) * (2 * int'(ey) + 1) : int'(ex) * int'(ey);
      if ($urandom_range(0, 9) == 0) n_pix = $urandom_range(0, n_pix);
      else if ($urandom_range(0, 9) == 0) n_pix++;
    end
    send_item(ell ? rer_pkg::CMD_ELLIPSE : rer_pkg::CMD_RECT, ox, oy, ex, ey, KB'($urandom));
    repeat (n_pix)
      send_item(rer_pkg::CMD_NEXT, CB'($urandom), CB'($urandom), SB'($urandom),
                SB'($urandom), KB'($urandom));
  endtask

  // receiver, with long hold-offs on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_reqs) begin
      stall_served <= stall_served + 1;
      stall_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : pixel_monitor
    pixel_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{pixel_x, pixel_y, pixel_color, draw, last};
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d c=%06h d=%0b l=%0b",
                         got.x, got.y, got.color, got.draw, got.last));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want)
          report($sformatf({"pixel %0d: got x=%0d y=%0d c=%06h d=%0b l=%0b, ",
                            "want x=%0d y=%0d c=%06h d=%0b l=%0b"},
                           pixels_seen, got.x, got.y, got.color, got.draw, got.last,
                           want.x, want.y, want.color, want.draw, want.last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WD_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    pixel_t pix;
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_check(rer_pkg::REG_WIDTH, int'(rer_pkg::WIDTH_RESET));
    apb_check(rer_pkg::REG_HEIGHT, int'(rer_pkg::HEIGHT_RESET));
    set_idle(0);
    foreach (DIR_ROWS[i]) begin
      send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].ox, DIR_ROWS[i].oy, DIR_ROWS[i].ex,
                DIR_ROWS[i].ey, DIR_ROWS[i].col);
      if (DIR_ROWS[i].chk != CHK_MODEL) begin
        if (last_kind == ITEM_PIXEL) pix = pending_pixels.pop_back();
        if (DIR_ROWS[i].chk == CHK_PIXEL) pending_pixels.push_back(DIR_ROWS[i].want);
      end
    end
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      set_idle(ph / 2);
      set_clip(PHASE_W[ph], PHASE_H[ph]);
      if (ph == 1 || ph == 4) stall_reqs <= stall_reqs + 1;
      target = eff_items + PHASE_ITEMS;
      while (eff_items < target) draw_shape();
      // empty rectangle leaves no shape open across the clip change
      send_item(rer_pkg::CMD_RECT, '0, '0, '0, '0, '0);
    end
    settle();
    $display("covered %0d shapes and %0d pixels over %0d clip settings,",
             shapes_begun, pixels_seen, N_PHASES + 1);
    $display("with three idling mixes and two long output stalls");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
